>>> rtl/ipv4ck_pkg.sv
`default_nettype none

package ipv4ck_pkg;

   // IP protocol numbers handled by the offload
   localparam logic [7:0] PROTO_ICMP = 8'd1;
   localparam logic [7:0] PROTO_TCP  = 8'd6;
   localparam logic [7:0] PROTO_UDP  = 8'd17;

   // transport_kind codes
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_TCP  = 2'd1;
   localparam logic [1:0] KIND_UDP  = 2'd2;
   localparam logic [1:0] KIND_ICMP = 2'd3;

   // status codes
   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_MALFORMED = 1'b1;

   // fixed header byte positions
   localparam logic [15:0] IDX_IHL      = 16'd0;
   localparam logic [15:0] IDX_TLEN_LO  = 16'd3;
   localparam logic [15:0] IDX_FRAG_LO  = 16'd7;
   localparam logic [15:0] IDX_PROTO    = 16'd9;
   localparam logic [15:0] IDX_HCK_HI   = 16'd10;
   localparam logic [15:0] IDX_HCK_LO   = 16'd11;
   localparam logic [15:0] PSEUDO_FIRST = 16'd12;
   localparam logic [15:0] PSEUDO_LAST  = 16'd19;
   localparam logic [15:0] INDEX_MAX    = 16'hFFFF;

   // offsets from the start of the transport header
   localparam logic [16:0] TCP_CK_OFS   = 17'd16;
   localparam logic [16:0] UDP_CK_OFS   = 17'd6;
   localparam logic [16:0] ICMP_CK_OFS  = 17'd2;
   localparam logic [16:0] UDP_LEN_OFS  = 17'd5;
   localparam logic [16:0] TCP_DOFF_OFS = 17'd12;
   localparam logic [16:0] UDP_HDR_OFS  = 17'd6;

   // length rules
   localparam logic [3:0]  MIN_IHL       = 4'd5;
   localparam logic [5:0]  MIN_HDR_BYTES = 6'd20;
   localparam logic [3:0]  MIN_TCP_DOFF  = 4'd5;
   localparam logic [15:0] MIN_TCP_LEN   = 16'd20;
   localparam logic [15:0] MIN_UDP_LEN   = 16'd8;
   localparam logic [15:0] MIN_ICMP_LEN  = 16'd4;

   localparam logic [15:0] ALL_ONES = 16'hFFFF;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_word_type;

   typedef struct packed {
      logic [15:0] header_checksum;
      logic [15:0] transport_checksum;
      logic [1:0]  transport_kind;
      logic        status;
   } rsp_word_type;

   // header state captured on the last byte of a packet
   typedef struct packed {
      logic [3:0]  header_words;
      logic [15:0] total_length;
      logic [7:0]  protocol_number;
      logic        is_fragment;
      logic [16:0] header_sum;
      logic [16:0] transport_sum;
      logic [15:0] udp_length;
      logic [3:0]  tcp_offset_words;
      logic [16:0] recv_count;
   } snap_type;

   // one's complement add with a single end-around fold; s stays <= 0x10000
   function automatic logic [16:0] oc_add(input logic [16:0] s, input logic [15:0] w);
      logic [17:0] t;
      t = {1'b0, s} + {2'b00, w};
      return {1'b0, t[15:0]} + {15'd0, t[17:16]};
   endfunction

   // two folds, then invert
   function automatic logic [15:0] oc_final(input logic [17:0] s);
      logic [16:0] f1;
      logic [16:0] f2;
      f1 = {1'b0, s[15:0]} + {15'd0, s[17:16]};
      f2 = {1'b0, f1[15:0]} + {16'd0, f1[16]};
      return ~f2[15:0];
   endfunction

   function automatic logic [1:0] kind_of(input logic [7:0] proto);
      logic [1:0] k;
      case (proto)
         PROTO_TCP:  k = KIND_TCP;
         PROTO_UDP:  k = KIND_UDP;
         PROTO_ICMP: k = KIND_ICMP;
         default:    k = KIND_NONE;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

>>> rtl/ipv4ck_req_if.sv
`default_nettype none

interface ipv4ck_req_if;
   logic                      valid;
   logic                      ready;
   ipv4ck_pkg::req_word_type  word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

`default_nettype wire

>>> rtl/ipv4ck_rsp_if.sv
`default_nettype none

interface ipv4ck_rsp_if;
   logic                      valid;
   logic                      ready;
   ipv4ck_pkg::rsp_word_type  word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

`default_nettype wire

>>> rtl/ipv4_full_checksum_recompute_core.sv
`default_nettype none

// Channel    Dir   Word fields                                            Handshake
// req_chan   in    data_byte[7:0], last_byte                              valid/ready
// rsp_chan   out   header_checksum[15:0], transport_checksum[15:0],       valid/ready
//                  transport_kind[1:0], status
//
// One byte is taken per cycle unless a last byte waits for the snapshot register; each byte
// pair needs one folded add into a running sum. Once the input register takes the last byte,
// the result passes the snapshot register, sum register and result register in that order.
// Synchronous active-high reset clears all valids and per-packet state.
// A stalled result holds the pipeline behind it; bytes of the next packet keep
// flowing until a second last byte needs the snapshot register.

module ipv4_full_checksum_recompute_core (
   input  logic          clock,
   input  logic          reset,
   ipv4ck_req_if.sink    req_chan,
   ipv4ck_rsp_if.source  rsp_chan
);

   ipv4ck_pkg::snap_type snap_word;
   logic                 snap_valid;
   logic                 snap_ready;

   ipv4ck_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .snap_word  (snap_word),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready)
   );

   ipv4ck_final u_final (
      .clock      (clock),
      .reset      (reset),
      .snap_word  (snap_word),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire

>>> rtl/ipv4ck_accum.sv
`default_nettype none

module ipv4ck_accum (
   input  logic                 clock,
   input  logic                 reset,
   ipv4ck_req_if.sink           req_chan,
   output ipv4ck_pkg::snap_type snap_word,
   output logic                 snap_valid,
   input  logic                 snap_ready
);

   // input register
   logic       s0_valid_ff;
   logic [7:0] s0_byte_ff;
   logic       s0_last_ff;
   logic       s0_take;

   // per-packet state
   logic [15:0] byte_index_ff,     byte_index_in;
   logic [3:0]  header_words_ff,   header_words_in;
   logic [15:0] total_length_ff,   total_length_in;
   logic [7:0]  protocol_ff,       protocol_in;
   logic        is_fragment_ff,    is_fragment_in;
   logic [16:0] header_sum_ff,     header_sum_in;
   logic [16:0] transport_sum_ff,  transport_sum_in;
   logic [15:0] udp_length_ff,     udp_length_in;
   logic [3:0]  tcp_offset_ff,     tcp_offset_in;
   logic [7:0]  high_hold_ff,      high_hold_in;

   logic                 snap_valid_ff;
   ipv4ck_pkg::snap_type snap_word_ff, snap_word_in;

   logic [5:0]  hlen;
   logic [16:0] hlen17;
   logic [16:0] idx17;
   logic        hdr_ok;
   logic        ck_en;
   logic [16:0] ck_pos;
   logic        zero_ck;
   logic [7:0]  eff;
   logic        in_tr;
   logic [16:0] udp_end;
   logic [16:0] tend;
   logic        counted;
   logic        pseudo_hit;
   logic [15:0] pair;

   assign s0_take = s0_valid_ff && (!s0_last_ff || !snap_valid_ff || snap_ready);
   assign req_chan.ready = !s0_valid_ff || s0_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s0_valid_ff <= req_chan.valid;
      end
      if (req_chan.ready && req_chan.valid) begin
         s0_byte_ff <= req_chan.word.data_byte;
         s0_last_ff <= req_chan.word.last_byte;
      end
   end

   always_comb begin
      header_words_in = (byte_index_ff == ipv4ck_pkg::IDX_IHL) ? s0_byte_ff[3:0]
                                                                : header_words_ff;
      total_length_in = (byte_index_ff == ipv4ck_pkg::IDX_TLEN_LO) ?
                        {high_hold_ff, s0_byte_ff} : total_length_ff;
      is_fragment_in  = (byte_index_ff == ipv4ck_pkg::IDX_FRAG_LO) ?
                        ({high_hold_ff[5:0], s0_byte_ff} != 14'd0) : is_fragment_ff;
      protocol_in     = (byte_index_ff == ipv4ck_pkg::IDX_PROTO) ? s0_byte_ff : protocol_ff;

      hlen   = {header_words_in, 2'b00};
      hlen17 = {11'd0, hlen};
      idx17  = {1'b0, byte_index_ff};
      hdr_ok = hlen >= ipv4ck_pkg::MIN_HDR_BYTES;

      ck_en  = 1'b1;
      case (protocol_in)
         ipv4ck_pkg::PROTO_TCP:  ck_pos = hlen17 + ipv4ck_pkg::TCP_CK_OFS;
         ipv4ck_pkg::PROTO_UDP:  ck_pos = hlen17 + ipv4ck_pkg::UDP_CK_OFS;
         ipv4ck_pkg::PROTO_ICMP: ck_pos = hlen17 + ipv4ck_pkg::ICMP_CK_OFS;
         default: begin
            ck_pos = '0;
            ck_en  = 1'b0;
         end
      endcase
      // old checksum fields read as zero
      zero_ck = ck_en && hdr_ok && (idx17 == ck_pos || idx17 == ck_pos + 17'd1);
      eff = (byte_index_ff == ipv4ck_pkg::IDX_HCK_HI || byte_index_ff == ipv4ck_pkg::IDX_HCK_LO
             || zero_ck) ? 8'd0 : s0_byte_ff;

      in_tr = hdr_ok && idx17 >= hlen17;
      udp_length_in = (in_tr && idx17 == hlen17 + ipv4ck_pkg::UDP_LEN_OFS) ?
                      {high_hold_ff, s0_byte_ff} : udp_length_ff;
      tcp_offset_in = (in_tr && idx17 == hlen17 + ipv4ck_pkg::TCP_DOFF_OFS) ?
                      s0_byte_ff[7:4] : tcp_offset_ff;

      // UDP sum stops at the UDP length once it is known
      udp_end = hlen17 + {1'b0, udp_length_in};
      tend    = {1'b0, total_length_in};
      if (in_tr && protocol_in == ipv4ck_pkg::PROTO_UDP
          && idx17 >= hlen17 + ipv4ck_pkg::UDP_HDR_OFS && udp_end < tend) begin
         tend = udp_end;
      end
      counted = in_tr && idx17 < tend;

      pseudo_hit = (byte_index_ff inside {[ipv4ck_pkg::PSEUDO_FIRST:ipv4ck_pkg::PSEUDO_LAST]})
                   && (protocol_in inside {ipv4ck_pkg::PROTO_TCP, ipv4ck_pkg::PROTO_UDP});
      pair = {high_hold_ff, eff};

      header_sum_in    = header_sum_ff;
      transport_sum_in = transport_sum_ff;
      high_hold_in     = high_hold_ff;
      if (byte_index_ff[0]) begin
         if (idx17 < hlen17) begin
            header_sum_in = ipv4ck_pkg::oc_add(header_sum_ff, pair);
         end
         if (pseudo_hit || counted) begin
            transport_sum_in = ipv4ck_pkg::oc_add(transport_sum_ff, pair);
         end
      end else begin
         high_hold_in = eff;
         // odd-length tail: pad with a zero low byte
         if (counted && idx17 + 17'd1 == tend) begin
            transport_sum_in = ipv4ck_pkg::oc_add(transport_sum_ff, {eff, 8'h00});
         end
      end

      byte_index_in = (byte_index_ff != ipv4ck_pkg::INDEX_MAX) ? byte_index_ff + 16'd1
                                                               : byte_index_ff;

      snap_word_in.header_words     = header_words_in;
      snap_word_in.total_length     = total_length_in;
      snap_word_in.protocol_number  = protocol_in;
      snap_word_in.is_fragment      = is_fragment_in;
      snap_word_in.header_sum       = header_sum_in;
      snap_word_in.transport_sum    = transport_sum_in;
      snap_word_in.udp_length       = udp_length_in;
      snap_word_in.tcp_offset_words = tcp_offset_in;
      snap_word_in.recv_count       = idx17 + 17'd1;
   end

   always_ff @(posedge clock) begin
      if (reset || (s0_take && s0_last_ff)) begin
         byte_index_ff    <= '0;
         header_words_ff  <= '0;
         total_length_ff  <= '0;
         protocol_ff      <= '0;
         is_fragment_ff   <= 1'b0;
         header_sum_ff    <= '0;
         transport_sum_ff <= '0;
         udp_length_ff    <= '0;
         tcp_offset_ff    <= '0;
         high_hold_ff     <= '0;
      end else if (s0_take) begin
         byte_index_ff    <= byte_index_in;
         header_words_ff  <= header_words_in;
         total_length_ff  <= total_length_in;
         protocol_ff      <= protocol_in;
         is_fragment_ff   <= is_fragment_in;
         header_sum_ff    <= header_sum_in;
         transport_sum_ff <= transport_sum_in;
         udp_length_ff    <= udp_length_in;
         tcp_offset_ff    <= tcp_offset_in;
         high_hold_ff     <= high_hold_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
      end else if (s0_take && s0_last_ff) begin
         snap_valid_ff <= 1'b1;
      end else if (snap_ready) begin
         snap_valid_ff <= 1'b0;
      end
      if (s0_take && s0_last_ff) begin
         snap_word_ff <= snap_word_in;
      end
   end

   assign snap_valid = snap_valid_ff;
   assign snap_word  = snap_word_ff;

   a_restart: assert property (@(posedge clock) disable iff (reset)
      s0_take && s0_last_ff |=> byte_index_ff == '0 && transport_sum_ff == '0)
      else $error("packet state not cleared after last byte");

   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      header_sum_ff <= 17'h10000 && transport_sum_ff <= 17'h10000)
      else $error("running sum exceeds folded range");

   a_snap_hold: assert property (@(posedge clock) disable iff (reset)
      snap_valid_ff && !snap_ready |=> snap_valid_ff && $stable(snap_word_ff))
      else $error("snapshot lost while stalled");

endmodule

`default_nettype wire

>>> rtl/ipv4ck_final.sv
`default_nettype none

module ipv4ck_final (
   input  logic                 clock,
   input  logic                 reset,
   input  ipv4ck_pkg::snap_type snap_word,
   input  logic                 snap_valid,
   output logic                 snap_ready,
   ipv4ck_rsp_if.source         rsp_chan
);

   typedef struct packed {
      logic [16:0] header_sum;
      logic [17:0] transport_raw;
      logic [15:0] tlen;
      logic        bad_base;
      logic        is_fragment;
      logic [1:0]  kind;
      logic [15:0] udp_length;
      logic [3:0]  tcp_offset_words;
   } prep_type;

   logic     prep_valid_ff;
   prep_type prep_ff, prep_in;

   logic                     out_valid_ff;
   ipv4ck_pkg::rsp_word_type out_word_ff, out_word_in;
   logic                     out_ready;

   logic [15:0] hlen16;
   logic [16:0] addend;
   logic        bad;
   logic [15:0] tsum;

   assign out_ready  = !out_valid_ff || rsp_chan.ready;
   assign snap_ready = !prep_valid_ff || out_ready;

   // first stage: length checks and pseudo-header tail into one raw sum
   always_comb begin
      hlen16 = {10'd0, snap_word.header_words, 2'b00};
      prep_in.header_sum       = snap_word.header_sum;
      prep_in.tlen             = snap_word.total_length - hlen16;
      prep_in.bad_base         = snap_word.header_words < ipv4ck_pkg::MIN_IHL
                                 || snap_word.total_length < hlen16
                                 || snap_word.recv_count < {1'b0, snap_word.total_length};
      prep_in.is_fragment      = snap_word.is_fragment;
      prep_in.kind             = ipv4ck_pkg::kind_of(snap_word.protocol_number);
      prep_in.udp_length       = snap_word.udp_length;
      prep_in.tcp_offset_words = snap_word.tcp_offset_words;
      case (prep_in.kind)
         ipv4ck_pkg::KIND_TCP: addend = {1'b0, prep_in.tlen} + 17'd6;
         ipv4ck_pkg::KIND_UDP: addend = {1'b0, snap_word.udp_length} + 17'd17;
         default:              addend = '0;
      endcase
      prep_in.transport_raw = {1'b0, snap_word.transport_sum} + {1'b0, addend};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (snap_ready) begin
         prep_valid_ff <= snap_valid;
      end
      if (snap_ready && snap_valid) begin
         prep_ff <= prep_in;
      end
   end

   // second stage: transport length rules, fold and invert
   always_comb begin
      bad = prep_ff.bad_base;
      if (!prep_ff.bad_base && !prep_ff.is_fragment) begin
         case (prep_ff.kind)
            ipv4ck_pkg::KIND_TCP:
               bad = prep_ff.tlen < ipv4ck_pkg::MIN_TCP_LEN
                     || prep_ff.tcp_offset_words < ipv4ck_pkg::MIN_TCP_DOFF
                     || {10'd0, prep_ff.tcp_offset_words, 2'b00} > prep_ff.tlen;
            ipv4ck_pkg::KIND_UDP:
               bad = prep_ff.tlen < ipv4ck_pkg::MIN_UDP_LEN
                     || prep_ff.udp_length < ipv4ck_pkg::MIN_UDP_LEN
                     || prep_ff.udp_length > prep_ff.tlen;
            ipv4ck_pkg::KIND_ICMP:
               bad = prep_ff.tlen < ipv4ck_pkg::MIN_ICMP_LEN;
            default:
               bad = 1'b0;
         endcase
      end

      tsum = ipv4ck_pkg::oc_final(prep_ff.transport_raw);
      // UDP sends a zero sum as all ones
      if (prep_ff.kind == ipv4ck_pkg::KIND_UDP && tsum == 16'd0) begin
         tsum = ipv4ck_pkg::ALL_ONES;
      end

      out_word_in.header_checksum    = '0;
      out_word_in.transport_checksum = '0;
      out_word_in.transport_kind     = ipv4ck_pkg::KIND_NONE;
      out_word_in.status             = ipv4ck_pkg::STATUS_MALFORMED;
      if (!bad) begin
         out_word_in.status          = ipv4ck_pkg::STATUS_OK;
         out_word_in.header_checksum = ipv4ck_pkg::oc_final({1'b0, prep_ff.header_sum});
         if (!prep_ff.is_fragment && prep_ff.kind != ipv4ck_pkg::KIND_NONE) begin
            out_word_in.transport_checksum = tsum;
            out_word_in.transport_kind     = prep_ff.kind;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= prep_valid_ff;
      end
      if (out_ready && prep_valid_ff) begin
         out_word_ff <= out_word_in;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.word  = out_word_ff;

   a_bad_clean: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_word_ff.status == ipv4ck_pkg::STATUS_MALFORMED |->
         out_word_ff.header_checksum == '0 && out_word_ff.transport_checksum == '0
         && out_word_ff.transport_kind == ipv4ck_pkg::KIND_NONE)
      else $error("malformed word carries checksums");

   a_udp_nonzero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_word_ff.transport_kind == ipv4ck_pkg::KIND_UDP |->
         out_word_ff.transport_checksum != '0)
      else $error("UDP checksum sent as zero");

   a_prep_hold: assert property (@(posedge clock) disable iff (reset)
      prep_valid_ff && !out_ready |=> prep_valid_ff && $stable(prep_ff))
      else $error("prepared sum lost while stalled");

endmodule

`default_nettype wire
